[src/tlbpfa_pkg.sv]
// ----------------------------------------------------------------------------
// tlbpfa_pkg
// Shared types and constants of the TLB / page table / frame allocator block.
// ----------------------------------------------------------------------------
package tlbpfa_pkg;

    localparam int TLB_DEPTH  = 16;
    localparam int MAX_FRAMES = 256;
    localparam int PID_SLOTS  = 16;
    localparam int MAX_PAGES  = 64;

    localparam int TLB_IW   = $clog2(TLB_DEPTH);
    localparam int FRAME_W  = $clog2(MAX_FRAMES);
    localparam int PID_IW   = $clog2(PID_SLOTS);
    localparam int PAGE_IW  = $clog2(MAX_PAGES);
    localparam int MAP_AW   = PID_IW + PAGE_IW;
    localparam int MAP_DEPTH = PID_SLOTS * MAX_PAGES;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_SIZE  = 2'd0;
    localparam logic [1:0] CFG_FRAMES_USED = 2'd1;
    localparam logic [1:0] CFG_TLB_USED    = 2'd2;
    localparam logic [1:0] CFG_TLB_ENABLE  = 2'd3;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_READ    = 2'd1,
        OP_FLUSH   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_TABLE  = 2'd1,
        ST_UNMAPPED  = 2'd2,
        ST_NO_FRAMES = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_COUNT,
        S_CHECK,
        S_ALLOC,
        S_MAP,
        S_MUL,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    take_hit;
        logic    set_status;
        status_t status_code;
        logic    count_step;
        logic    clr_scan;
        logic    alloc_step;
        logic    write_held;
        logic    take_map;
        logic    mul;
        logic    flush;
        logic    emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic pid_ok;
        logic count_big;
        logic tlb_hit;
        logic page_bad;
        logic scan_end;
        logic alloc_end;
        logic free_short;
        logic out_busy;
        logic clear_busy;
    } sts_t;

endpackage

[src/tlbpfa_ram.sv]
// ----------------------------------------------------------------------------
// tlbpfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/tlbpfa_ctrl.sv]
// ----------------------------------------------------------------------------
// tlbpfa_ctrl
// Sequencer for reserve, read and flush transactions.
// ----------------------------------------------------------------------------
module tlbpfa_ctrl
    import tlbpfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_accept,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // Hold off requests until the frame bitmap is cleared
                in_ready = !sts.clear_busy;
                if (in_accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
                case (sts.op)
                    OP_RESERVE:
                    begin
                        if (!sts.pid_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_TABLE;
                        end
                        else if (sts.count_big)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_FRAMES;
                        end
                        else
                        begin
                            state_next = S_COUNT;
                        end
                    end
                    OP_READ:
                    begin
                        if (sts.tlb_hit)
                        begin
                            cmd.take_hit = 1'b1;
                            state_next   = S_MUL;
                        end
                        else if (!sts.pid_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NO_TABLE;
                        end
                        else if (sts.page_bad)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_UNMAPPED;
                        end
                        else
                        begin
                            state_next = S_MAP;
                        end
                    end
                    OP_FLUSH:
                    begin
                        cmd.flush = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_COUNT:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.count_step = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (sts.free_short)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NO_FRAMES;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.clr_scan = 1'b1;
                    state_next   = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (sts.alloc_end)
                begin
                    cmd.write_held = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.alloc_step = 1'b1;
                end
            end
            S_MAP:
            begin
                cmd.take_map = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/tlbpfa_dp.sv]
// ----------------------------------------------------------------------------
// tlbpfa_dp
// Datapath: configuration, TLB, frame bitmap, page table and address math.
// ----------------------------------------------------------------------------
module tlbpfa_dp
    import tlbpfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic [47:0] in_data,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [39:0] out_data,
    input  cmd_t        cmd,
    output sts_t        sts
);

    // Configuration registers
    logic [12:0] frame_size_reg;
    logic [8:0]  frames_used_reg;
    logic [4:0]  tlb_used_reg;
    logic        tlb_enable_reg;

    // Captured request
    op_t         op_reg;
    logic [7:0]  pid_reg;
    logic [5:0]  page_reg;
    logic [11:0] off_reg;
    logic [11:0] bytes_reg;
    logic [6:0]  cnt_reg;

    // Working state
    status_t              status_reg;
    logic                 hit_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [20:0]          prod_reg;
    logic [8:0]           f_reg;
    logic [8:0]           f_next;
    logic [6:0]           p_reg;
    logic [8:0]           free_reg;

    // Stores
    logic [TLB_DEPTH-1:0] tlb_valid_reg;
    logic [PID_IW-1:0]    tlb_proc_reg  [TLB_DEPTH];
    logic [PAGE_IW-1:0]   tlb_vpage_reg [TLB_DEPTH];
    logic [FRAME_W-1:0]   tlb_frame_reg [TLB_DEPTH];
    logic [6:0]           held_reg [PID_SLOTS];

    // Frame bitmap clearing pass after reset
    logic [8:0]           clr_reg;
    logic                 clearing;

    // Output register
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic [39:0] out_word;

    logic [8:0]         lim;
    logic [4:0]         slots;
    logic               hit_any;
    logic [FRAME_W-1:0] hit_frame;
    logic               fill_ok;
    logic [TLB_IW-1:0]  fill_idx;
    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr;
    logic [MAP_AW-1:0]  map_raddr;
    logic [FRAME_W-1:0] map_rdata;
    logic               busy_bit;
    logic               busy_we;
    logic [FRAME_W-1:0] busy_waddr;
    logic               busy_wdata;
    logic [19:0]        addr;

    assign lim   = (frames_used_reg > 9'(MAX_FRAMES)) ? 9'(MAX_FRAMES) : frames_used_reg;
    assign slots = (tlb_used_reg > 5'(TLB_DEPTH)) ? 5'(TLB_DEPTH) : tlb_used_reg;

    // Search the TLB for a match and for the first empty slot
    always_comb
    begin
        hit_any   = 1'b0;
        hit_frame = '0;
        fill_ok   = 1'b0;
        fill_idx  = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (5'(i) < slots)
            begin
                if (tlb_valid_reg[i] && ({4'd0, tlb_proc_reg[i]} == pid_reg)
                    && (tlb_vpage_reg[i] == page_reg))
                begin
                    hit_any   = 1'b1;
                    hit_frame = tlb_frame_reg[i];
                end
                if (!tlb_valid_reg[i])
                begin
                    fill_ok  = 1'b1;
                    fill_idx = TLB_IW'(i);
                end
            end
        end
    end

    // Next scan position; the bitmap RAM reads it ahead, so its registered bit matches f_reg
    always_comb
    begin
        f_next = f_reg;
        if (cmd.load || cmd.clr_scan)
        begin
            f_next = '0;
        end
        else if (cmd.count_step || cmd.alloc_step)
        begin
            f_next = f_reg + 9'd1;
        end
    end

    // Status toward the controller
    assign sts.op         = op_reg;
    assign sts.pid_ok     = (pid_reg < 8'(PID_SLOTS)) && ({1'b0, pid_reg} < frames_used_reg);
    assign sts.count_big  = cnt_reg > 7'(MAX_PAGES);
    assign sts.tlb_hit    = tlb_enable_reg && hit_any;
    assign sts.page_bad   = {1'b0, page_reg} >= held_reg[pid_reg[PID_IW-1:0]];
    assign sts.scan_end   = f_reg >= lim;
    assign sts.alloc_end  = (f_reg >= lim) || (p_reg == cnt_reg);
    assign sts.free_short = free_reg < {2'd0, cnt_reg};
    assign sts.out_busy   = out_valid_reg && !out_ready;
    assign sts.clear_busy = clearing;

    // Page table memory
    assign map_we    = cmd.alloc_step && !busy_bit;
    assign map_waddr = {pid_reg[PID_IW-1:0], p_reg[PAGE_IW-1:0]};
    assign map_raddr = {pid_reg[PID_IW-1:0], page_reg};

    tlbpfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (f_reg[FRAME_W-1:0]),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // After reset, clear the frame bitmap one frame a cycle
    assign clearing = !clr_reg[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 9'd1;
        end
    end

    // Frame bitmap memory: clear it after reset, mark a frame busy when it is taken
    assign busy_we    = clearing || map_we;
    assign busy_waddr = clearing ? clr_reg[FRAME_W-1:0] : f_reg[FRAME_W-1:0];
    assign busy_wdata = !clearing;

    tlbpfa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_FRAMES)
    ) u_busy (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .raddr (f_next[FRAME_W-1:0]),
        .rdata (busy_bit)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg  <= 13'd256;
            frames_used_reg <= 9'd256;
            tlb_used_reg    <= 5'd16;
            tlb_enable_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_SIZE:  frame_size_reg  <= cfg_data;
                CFG_FRAMES_USED: frames_used_reg <= cfg_data[8:0];
                CFG_TLB_USED:    tlb_used_reg    <= cfg_data[4:0];
                CFG_TLB_ENABLE:  tlb_enable_reg  <= cfg_data[0];
                default:         tlb_enable_reg  <= tlb_enable_reg;
            endcase
        end
    end

    // Capture request and hold working values
    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        if (cmd.load)
        begin
            op_reg     <= op_t'(in_data[1:0]);
            pid_reg    <= in_data[9:2];
            page_reg   <= in_data[15:10];
            off_reg    <= in_data[27:16];
            bytes_reg  <= in_data[39:28];
            cnt_reg    <= in_data[46:40];
            status_reg <= ST_OK;
            hit_reg    <= 1'b0;
            p_reg      <= '0;
            free_reg   <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.take_hit)
        begin
            frame_reg <= hit_frame;
            hit_reg   <= 1'b1;
        end
        if (cmd.take_map)
        begin
            frame_reg <= map_rdata;
        end
        if (cmd.mul)
        begin
            prod_reg <= 21'(frame_reg * frame_size_reg);
        end
        if (cmd.count_step && !busy_bit)
        begin
            free_reg <= free_reg + 9'd1;
        end
        if (cmd.alloc_step && !busy_bit)
        begin
            p_reg <= p_reg + 7'd1;
        end
    end

    // TLB entry payload: fill the first empty slot after a table walk
    always_ff @(posedge clk)
    begin
        if (cmd.take_map && fill_ok)
        begin
            tlb_proc_reg[fill_idx]  <= pid_reg[PID_IW-1:0];
            tlb_vpage_reg[fill_idx] <= page_reg;
            tlb_frame_reg[fill_idx] <= map_rdata;
        end
    end

    // Stores with a reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg <= '0;
            for (int i = 0; i < PID_SLOTS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.flush)
            begin
                tlb_valid_reg <= '0;
            end
            else if (cmd.take_map && fill_ok)
            begin
                tlb_valid_reg[fill_idx] <= 1'b1;
            end
            if (cmd.write_held)
            begin
                held_reg[pid_reg[PID_IW-1:0]] <= cnt_reg;
            end
        end
    end

    // Physical address: frame base plus offset
    assign addr = prod_reg[19:0] + {8'd0, off_reg};

    // Assemble the result word
    always_comb
    begin
        out_word       = '0;
        out_word[1:0]  = status_reg;
        if (op_reg == OP_READ)
        begin
            out_word[2]     = hit_reg;
            out_word[34:23] = bytes_reg;
            if (status_reg == ST_OK)
            begin
                out_word[22:3] = addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= out_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/tlb_page_translation_frame_allocator_top.sv]
// ----------------------------------------------------------------------------
// tlb_page_translation_frame_allocator_top
// TLB, per-process page tables and first-fit frame allocator.
//
// Channel    Dir  Handshake                  Payload
// cfg        in   cfg_valid / cfg_ready      cfg_index, cfg_data
// s_axis     in   s_axis_tvalid / tready     s_axis_tdata (request)
// m_axis     out  m_axis_tvalid / tready     m_axis_tdata (result)
//
// A read that hits the TLB goes from lookup to multiply to result; one that
// misses walks the page table first (registered page-table RAM read). A reserve
// scans the frame bitmap one frame a cycle, twice, over min(frames_in_use, 256)
// frames at most. Flush and unused operations go straight to the result. One
// request is in work at a time; a stalled result holds the sequencer in its last
// step. After reset the frame bitmap RAM is cleared one frame a cycle, holding
// off requests until it is done; the TLB and the page counts clear at once.
// ----------------------------------------------------------------------------
module tlb_page_translation_frame_allocator_top
    import tlbpfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], pid[9:2], page[15:10], offset[27:16],
    // byte_count[39:28], pages_requested[46:40], zero[47]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], tlb_hit[2], physical_address[22:3], length[34:23],
    // zero[39:35]
    output logic [39:0] m_axis_tdata
);

    cmd_t cmd;
    sts_t sts;
    logic in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    tlbpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_ready  (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tlbpfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
